// ----- sv/lrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lrs_pkg
// shared types, constants and helpers of the life row stepper
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int CFG_W     = 7;
    localparam int CNT_W     = 4;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(MAX_WIDTH);

    // register index codes
    localparam logic REG_WIDTH_IN_USE = 1'b0;

    // neighbor counts of the rule
    localparam logic [CNT_W-1:0] BIRTH_COUNT   = CNT_W'(3);
    localparam logic [CNT_W-1:0] SURVIVE_COUNT = CNT_W'(2);

    typedef logic [MAX_WIDTH-1:0] row_t;

    typedef struct packed {
        logic [2:0] up;
        logic [2:0] mid;
        logic [2:0] down;
    } nbhd_t;

    function automatic row_t col_mask(input logic [CFG_W-1:0] width);
        row_t m;
        for (int k = 0; k < MAX_WIDTH; k++) begin
            m[k] = (width > CFG_W'(k));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- sv/lrs_lane.sv -----
// ----------------------------------------------------------------------------
// lrs_lane
// one column of the rule: counts the eight neighbors and decides the cell
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_lane (
    input  wire lrs_pkg::nbhd_t nbhd,
    output logic                alive
);
    import lrs_pkg::*;

    logic [CNT_W-1:0] count;

    always_comb begin
        count = {3'b000, nbhd.up[0]}   + {3'b000, nbhd.up[1]}   + {3'b000, nbhd.up[2]}
              + {3'b000, nbhd.mid[0]}                           + {3'b000, nbhd.mid[2]}
              + {3'b000, nbhd.down[0]} + {3'b000, nbhd.down[1]} + {3'b000, nbhd.down[2]};
        alive = (count == BIRTH_COUNT)
             || (nbhd.mid[1] && (count == SURVIVE_COUNT));
    end

endmodule

`default_nettype wire

// ----- sv/lrs_row_gen.sv -----
// ----------------------------------------------------------------------------
// lrs_row_gen
// one lane per column side by side, merged into a masked result row
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_row_gen (
    input  wire lrs_pkg::row_t            up_row,
    input  wire lrs_pkg::row_t            mid_row,
    input  wire lrs_pkg::row_t            down_row,
    input  wire [lrs_pkg::CFG_W-1:0]      width,
    output lrs_pkg::row_t                 next_row
);
    import lrs_pkg::*;

    logic [MAX_WIDTH+1:0] up_ext;
    logic [MAX_WIDTH+1:0] mid_ext;
    logic [MAX_WIDTH+1:0] down_ext;
    row_t                 lane_alive;

    // dead cells left of column 0 and right of the last column
    assign up_ext   = {1'b0, up_row,   1'b0};
    assign mid_ext  = {1'b0, mid_row,  1'b0};
    assign down_ext = {1'b0, down_row, 1'b0};

    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_lane
        nbhd_t nbhd;
        assign nbhd.up   = up_ext[k+2:k];
        assign nbhd.mid  = mid_ext[k+2:k];
        assign nbhd.down = down_ext[k+2:k];

        lrs_lane u_lane (
            .nbhd  (nbhd),
            .alive (lane_alive[k])
        );
    end

    assign next_row = lane_alive & col_mask(width);

endmodule

`default_nettype wire

// ----- sv/life_rule_row_stepper.sv -----
// ----------------------------------------------------------------------------
// life_rule_row_stepper
// one life generation (B3/S23) over a streamed grid with a dead border
// ----------------------------------------------------------------------------
// path: a result goes through the job register into the output register; the own
//   result of a multi-row frame's last row waits first in the pend register
// throughput: one row per cycle unless m_ready stalls the output; a multi-row
//   frame's last row holds off the next request while both of its results
//   pass the single lane array in turn
// reset (synchronous, aresetn low): rows cleared, no row held, width 64
// ----------------------------------------------------------------------------
`default_nettype none

module life_rule_row_stepper (
    input  wire                         aclk,
    input  wire                         aresetn,

    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [lrs_pkg::ADDR_W-1:0]   paddr,
    input  wire [lrs_pkg::DATA_W-1:0]   pwdata,
    output logic [lrs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,

    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire lrs_pkg::row_t          s_row_cells,
    input  wire                         s_last_row,

    output logic                        m_valid,
    input  wire                         m_ready,
    output lrs_pkg::row_t               m_next_cells,
    output logic                        m_last_out
);
    import lrs_pkg::*;

    logic [CFG_W-1:0] width_reg, width_next;

    row_t row_above_reg,  row_above_next;
    row_t row_middle_reg, row_middle_next;
    logic have_middle_reg, have_middle_next;

    logic job_valid_reg, job_valid_next;
    row_t job_up_reg,    job_up_next;
    row_t job_mid_reg,   job_mid_next;
    row_t job_down_reg,  job_down_next;
    logic job_last_reg,  job_last_next;

    logic pend_valid_reg, pend_valid_next;
    row_t pend_up_reg,    pend_up_next;
    row_t pend_mid_reg,   pend_mid_next;

    logic out_valid_reg, out_valid_next;
    row_t out_cells_reg, out_cells_next;
    logic out_last_reg,  out_last_next;

    logic out_adv;
    logic job_free;
    logic s_fire;
    logic cfg_write;
    row_t row_in;
    row_t gen_row;

    lrs_row_gen u_row_gen (
        .up_row   (job_up_reg),
        .mid_row  (job_mid_reg),
        .down_row (job_down_reg),
        .width    (width_reg),
        .next_row (gen_row)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1] == REG_WIDTH_IN_USE);

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1] == REG_WIDTH_IN_USE) begin
            prdata = {{(DATA_W-CFG_W){1'b0}}, width_reg};
        end
    end

    assign out_adv  = !out_valid_reg || m_ready;
    assign job_free = !job_valid_reg || out_adv;
    assign s_ready  = job_free && !pend_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign row_in   = s_row_cells & col_mask(width_reg);

    assign m_valid      = out_valid_reg;
    assign m_next_cells = out_cells_reg;
    assign m_last_out   = out_last_reg;

    always_comb begin
        width_next       = width_reg;
        row_above_next   = row_above_reg;
        row_middle_next  = row_middle_reg;
        have_middle_next = have_middle_reg;
        job_valid_next   = job_valid_reg;
        job_up_next      = job_up_reg;
        job_mid_next     = job_mid_reg;
        job_down_next    = job_down_reg;
        job_last_next    = job_last_reg;
        pend_valid_next  = pend_valid_reg;
        pend_up_next     = pend_up_reg;
        pend_mid_next    = pend_mid_reg;
        out_valid_next   = out_valid_reg;
        out_cells_next   = out_cells_reg;
        out_last_next    = out_last_reg;

        if (cfg_write) begin
            width_next = pwdata[CFG_W-1:0];
        end

        if (out_adv) begin
            out_valid_next = job_valid_reg;
            out_cells_next = gen_row;
            out_last_next  = job_last_reg;
        end

        if (job_free) begin
            job_valid_next = 1'b0;
        end

        if (s_fire) begin
            if (have_middle_reg) begin
                job_valid_next = 1'b1;
                job_up_next    = row_above_reg;
                job_mid_next   = row_middle_reg;
                job_down_next  = row_in;
                job_last_next  = 1'b0;
                row_above_next = row_middle_reg;
            end else begin
                row_above_next = '0;
            end
            row_middle_next  = row_in;
            have_middle_next = 1'b1;

            if (s_last_row) begin
                if (have_middle_reg) begin
                    pend_valid_next = 1'b1;
                    pend_up_next    = row_middle_reg;
                    pend_mid_next   = row_in;
                end else begin
                    job_valid_next = 1'b1;
                    job_up_next    = '0;
                    job_mid_next   = row_in;
                    job_down_next  = '0;
                    job_last_next  = 1'b1;
                end
                row_above_next   = '0;
                row_middle_next  = '0;
                have_middle_next = 1'b0;
            end
        end else if (pend_valid_reg && job_free) begin
            job_valid_next  = 1'b1;
            job_up_next     = pend_up_reg;
            job_mid_next    = pend_mid_reg;
            job_down_next   = '0;
            job_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg       <= WIDTH_RESET;
            row_above_reg   <= '0;
            row_middle_reg  <= '0;
            have_middle_reg <= 1'b0;
            job_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            width_reg       <= width_next;
            row_above_reg   <= row_above_next;
            row_middle_reg  <= row_middle_next;
            have_middle_reg <= have_middle_next;
            job_valid_reg   <= job_valid_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_up_reg    <= job_up_next;
        job_mid_reg   <= job_mid_next;
        job_down_reg  <= job_down_next;
        job_last_reg  <= job_last_next;
        pend_up_reg   <= pend_up_next;
        pend_mid_reg  <= pend_mid_next;
        out_cells_reg <= out_cells_next;
        out_last_reg  <= out_last_next;
    end

    // a held second result blocks new requests
    a_pend_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> !s_ready)
        else $error("request taken while second result pending");

    // the second result is only ever queued behind a first one
    a_pend_behind_job: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> job_valid_reg)
        else $error("second result pending without first in job stage");

    // a last row of a multi-row frame queues its own result
    a_last_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_last_row && have_middle_reg) |=> pend_valid_reg)
        else $error("last row result not queued");

    // a last row ends the frame
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_last_row) |=> !have_middle_reg)
        else $error("row state not cleared after last row");

endmodule

`default_nettype wire

// ----- sim/tb_life_rule_row_stepper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_rule_row_stepper
// self-checking bench for the streamed life generation stepper
// ----------------------------------------------------------------------------
// rows go in as requests over valid/ready with random gaps. A local model of
// the B3/S23 rule and the row window predicts every output row. Output rows are
// checked in order against that prediction while the sink stalls at random.
// The column width register is reprogrammed between frames over APB. This
// covers width 0, the saturating values and writes to an unmapped address.
// ----------------------------------------------------------------------------

module tb_life_rule_row_stepper;

    localparam int CFG_W       = lrs_pkg::CFG_W;
    localparam int ADDR_W      = lrs_pkg::ADDR_W;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 100000;
    localparam int N_PHASES    = 11;

    localparam logic [ADDR_W-1:0] ADDR_WIDTH_IN_USE = ADDR_W'(4 * lrs_pkg::REG_WIDTH_IN_USE);
    // index 1, no register there
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(4 * (lrs_pkg::REG_WIDTH_IN_USE + 1));

    typedef lrs_pkg::row_t row_t;

    typedef struct {
        row_t cells;
        logic last;
    } gen_row_t;

    logic                        aclk;
    logic                        aresetn     = 1'b0;
    logic                        psel        = 1'b0;
    logic                        penable     = 1'b0;
    logic                        pwrite      = 1'b0;
    logic [lrs_pkg::ADDR_W-1:0]  paddr       = '0;
    logic [lrs_pkg::DATA_W-1:0]  pwdata      = '0;
    logic [lrs_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    row_t                        s_row_cells = '0;
    logic                        s_last_row  = 1'b0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    row_t                        m_next_cells;
    logic                        m_last_out;

    // predictor state
    logic [CFG_W-1:0] width_cfg;
    row_t             win_above;
    row_t             win_middle;
    logic             win_holds_row;
    gen_row_t         expected_rows[$];
    gen_row_t         oldest_row;

    logic idle_on = 1'b1;
    int   cycle_count   = 0;
    int   n_mismatch    = 0;
    int   n_rows_sent   = 0;
    int   n_rows_seen   = 0;
    int   n_frames      = 0;
    int   n_pauses      = 0;
    int   n_width_writes = 0;

    life_rule_row_stepper DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_row_cells  (s_row_cells),
        .s_last_row   (s_last_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_cells (m_next_cells),
        .m_last_out   (m_last_out)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows pending", cycle_count,
                     expected_rows.size());
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 20);
    end

    task automatic report_mismatch(input string what);
        n_mismatch++;
        $display("mismatch @%0t: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_rows_seen++;
            if (expected_rows.size() == 0) begin
                report_mismatch($sformatf("output row %h with nothing pending", m_next_cells));
            end else begin
                oldest_row = expected_rows.pop_front();
                if (m_next_cells !== oldest_row.cells)
                    report_mismatch($sformatf("next_cells %h, want %h",
                                              m_next_cells, oldest_row.cells));
                if (m_last_out !== oldest_row.last)
                    report_mismatch($sformatf("last_out %b, want %b",
                                              m_last_out, oldest_row.last));
            end
        end
    end

    function automatic row_t live_columns(input logic [CFG_W-1:0] w);
        if (w >= lrs_pkg::MAX_WIDTH)
            return '1;
        return (row_t'(1) << w) - row_t'(1);
    endfunction

    function automatic row_t evolve_row(input row_t up, input row_t mid, input row_t down,
                                        input row_t keep);
        row_t u;
        row_t m;
        row_t d;
        row_t nxt;
        int   cnt;
        u = up & keep;
        m = mid & keep;
        d = down & keep;
        for (int c = 0; c < lrs_pkg::MAX_WIDTH; c++) begin
            cnt = 0;
            for (int dc = -1; dc <= 1; dc++) begin
                if (c + dc >= 0 && c + dc < lrs_pkg::MAX_WIDTH) begin
                    cnt = cnt + int'(u[c + dc]) + int'(d[c + dc]);
                    if (dc != 0)
                        cnt = cnt + int'(m[c + dc]);
                end
            end
            nxt[c] = (cnt == lrs_pkg::BIRTH_COUNT) || (m[c] && cnt == lrs_pkg::SURVIVE_COUNT);
        end
        return nxt & keep;
    endfunction

    // advance the row window by one accepted request
    function automatic void step_window(input row_t cells, input logic last);
        row_t     keep;
        row_t     r;
        gen_row_t g;
        keep = live_columns(width_cfg);
        r = cells & keep;
        if (win_holds_row) begin
            g.cells = evolve_row(win_above, win_middle, r, keep);
            g.last = 1'b0;
            expected_rows.push_back(g);
            win_above = win_middle;
        end else begin
            win_above = '0;
        end
        win_middle = r;
        win_holds_row = 1'b1;
        if (last) begin
            g.cells = evolve_row(win_above, win_middle, '0, keep);
            g.last = 1'b1;
            expected_rows.push_back(g);
            win_above = '0;
            win_middle = '0;
            win_holds_row = 1'b0;
            n_frames++;
        end
    endfunction

    function automatic row_t rand_row();
        return {$urandom, $urandom};
    endfunction

    function automatic row_t make_row();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return rand_row() & rand_row() & rand_row();
            4, 5: return rand_row() & rand_row();
            6: return rand_row() | rand_row();
            default: return rand_row();
        endcase
    endfunction

    task automatic send_row(input row_t cells, input logic last);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(99) < 20)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_row_cells <= rand_row();
            s_last_row <= 1'($urandom_range(1));
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_row_cells <= cells;
        s_last_row <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        step_window(cells, last);
        n_rows_sent++;
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [lrs_pkg::ADDR_W-1:0] addr,
                             input logic [lrs_pkg::DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == ADDR_WIDTH_IN_USE) begin
            width_cfg = data[CFG_W-1:0];
            n_width_writes++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_check_width();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_WIDTH_IN_USE;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[CFG_W-1:0] !== width_cfg)
            report_mismatch($sformatf("width_in_use reads %0d, want %0d",
                                      prdata[CFG_W-1:0], width_cfg));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_width(input int w);
        logic [lrs_pkg::DATA_W-1:0] data;
        wait_all_results();
        data = $urandom;
        data[CFG_W-1:0] = w[CFG_W-1:0];
        apb_write(ADDR_WIDTH_IN_USE, data);
        apb_check_width();
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) == 0) begin
                wait_all_results();
                n_pauses++;
            end
            send_row(make_row(), i == len - 1);
        end
    endtask

    function automatic int pick_frame_len();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 1;
        if (r < 20)
            return $urandom_range(13, 40);
        return $urandom_range(2, 12);
    endfunction

    task automatic test_reset_state();
        width_cfg = lrs_pkg::WIDTH_RESET;
        win_above = '0;
        win_middle = '0;
        win_holds_row = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_check_width();
    endtask

    task automatic test_directed_rows();
        // single-row frame, dead rows above and below
        send_row('1, 1'b1);
        // vertical blinker
        send_row(64'h2, 1'b0);
        send_row(64'h2, 1'b0);
        send_row(64'h2, 1'b1);
        // live corners at both ends of the row
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'hC000_0000_0000_0003, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        // checkerboard
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        // glider
        send_row(64'h2, 1'b0);
        send_row(64'h4, 1'b0);
        send_row(64'h7, 1'b1);
        wait_all_results();
    endtask

    task automatic test_width_register();
        // unmapped address must leave the width alone
        apb_write(ADDR_UNMAPPED, 32'h5);
        apb_check_width();
        send_row('1, 1'b0);
        send_row(rand_row(), 1'b1);
        set_width(1);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        set_width(0);
        send_row('1, 1'b0);
        send_row(rand_row(), 1'b1);
        set_width(127);
        send_row(rand_row(), 1'b0);
        send_row('1, 1'b1);
        set_width(3);
        send_row(64'h7, 1'b0);
        send_row('1, 1'b1);
        set_width(63);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        set_width(lrs_pkg::MAX_WIDTH);
    endtask

    task automatic test_stall_until_drained();
        for (int i = 0; i < 3; i++)
            send_row(make_row(), 1'b0);
        wait_all_results();
        n_pauses++;
        for (int i = 0; i < 3; i++)
            send_row(make_row(), i == 2);
        wait_all_results();
        n_pauses++;
    endtask

    task automatic test_random_frames();
        int budget[N_PHASES];
        int widths[N_PHASES];
        int sent;
        int len;
        budget = '{180, 80, 80, 100, 150, 120, 230, 180, 120, 20, 40};
        widths = '{64, 1, 2, 3, 0, 63, 64, 0, 32, 0, 100};
        widths[4] = $urandom_range(4, 62);
        widths[7] = $urandom_range(1, 64);
        for (int p = 0; p < N_PHASES; p++) begin
            set_width(widths[p]);
            // phase 6 runs with no gaps and no stalls
            idle_on = (p != 6);
            sent = 0;
            while (sent < budget[p]) begin
                len = pick_frame_len();
                if (len > budget[p] - sent)
                    len = budget[p] - sent;
                send_frame(len);
                sent += len;
            end
            wait_all_results();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        test_reset_state();
        test_directed_rows();
        test_width_register();
        test_stall_until_drained();
        test_random_frames();
        wait_all_results();
        $display("summary: %0d rows in %0d frames sent, %0d output rows checked",
                 n_rows_sent, n_frames, n_rows_seen);
        $display("summary: %0d width writes incl. 0, 1, 3, 63, 64, 127; %0d drain pauses",
                 n_width_writes, n_pauses);
        if (n_mismatch == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
